### sv/pvlu_pkg.sv
// shared types, codes and helpers of the planar vram logic unit
package pvlu_pkg;

  localparam int ADDR_W      = 14;
  localparam int DATA_W      = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int NUM_PLANES  = 3;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] DPLANE_NONE = 2'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALU_ENABLE,
    REG_PLANE_OPS,
    REG_COMPARE_COLOR,
    REG_WRITE_MODE,
    REG_DIRECT_PLANE
  } reg_idx_e;

  typedef enum logic [1:0] {
    WMODE_LOGIC,
    WMODE_RESTORE,
    WMODE_L1_TO_P0,
    WMODE_L0_TO_P1
  } wmode_e;

  typedef enum logic [1:0] {
    PLOP_CLEAR,
    PLOP_SET,
    PLOP_INVERT,
    PLOP_KEEP
  } plop_e;

  typedef enum logic [2:0] {
    KIND_IGNORE,
    KIND_DIRECT_RD,
    KIND_DIRECT_WR,
    KIND_ALU_RD,
    KIND_ALU_WR
  } kind_e;

  typedef struct packed {
    logic              alu_enable;
    logic [DATA_W-1:0] plane_ops;
    logic [2:0]        compare_color;
    wmode_e            write_mode;
    logic [1:0]        direct_plane;
  } cfg_t;

  typedef struct packed {
    kind_e             kind;
    logic [1:0]        plane;
    wmode_e            write_mode;
    logic [DATA_W-1:0] plane_ops;
    logic [2:0]        compare_color;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  // per-plane logic op, select is {ops[p+4], ops[p]}
  function automatic logic [DATA_W-1:0] apply_op(logic [DATA_W-1:0] cur,
                                                 logic [DATA_W-1:0] ops,
                                                 logic [1:0] p,
                                                 logic [DATA_W-1:0] d);
    logic [1:0]        sel;
    logic [DATA_W-1:0] res;
    sel = {ops[p + 3'd4], ops[p]};
    case (plop_e'(sel))
      PLOP_CLEAR:  res = cur & ~d;
      PLOP_SET:    res = cur | d;
      PLOP_INVERT: res = cur ^ d;
      default:     res = cur;
    endcase
    return res;
  endfunction

endpackage

### sv/pvlu_front.sv
// front end: configuration registers and classification of accepted accesses
module pvlu_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pvlu_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [pvlu_pkg::DATA_W-1:0]         cfg_wdata_i,
  input  logic                                accept_i,
  input  logic                                op_i,
  input  logic [pvlu_pkg::ADDR_W-1:0]         addr_i,
  input  logic [pvlu_pkg::DATA_W-1:0]         wdata_i,
  output logic                                push_o,
  output pvlu_pkg::cmd_t                      cmd_o
);

  pvlu_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pvlu_pkg::REG_ALU_ENABLE:    cfg_q.alu_enable    <= cfg_wdata_i[0];
        pvlu_pkg::REG_PLANE_OPS:     cfg_q.plane_ops     <= cfg_wdata_i;
        pvlu_pkg::REG_COMPARE_COLOR: cfg_q.compare_color <= cfg_wdata_i[2:0];
        pvlu_pkg::REG_WRITE_MODE:    cfg_q.write_mode    <= pvlu_pkg::wmode_e'(cfg_wdata_i[1:0]);
        pvlu_pkg::REG_DIRECT_PLANE:  cfg_q.direct_plane  <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  // classify and snapshot the config that the back end needs
  always_comb begin
    cmd_o.plane         = cfg_q.direct_plane - 2'd1;
    cmd_o.write_mode    = cfg_q.write_mode;
    cmd_o.plane_ops     = cfg_q.plane_ops;
    cmd_o.compare_color = cfg_q.compare_color;
    cmd_o.addr          = addr_i;
    cmd_o.wdata         = wdata_i;
    if (cfg_q.alu_enable) begin
      cmd_o.kind = op_i ? pvlu_pkg::KIND_ALU_WR : pvlu_pkg::KIND_ALU_RD;
    end else if (cfg_q.direct_plane == pvlu_pkg::DPLANE_NONE) begin
      cmd_o.kind = pvlu_pkg::KIND_IGNORE;
    end else begin
      cmd_o.kind = op_i ? pvlu_pkg::KIND_DIRECT_WR : pvlu_pkg::KIND_DIRECT_RD;
    end
  end

  assign push_o = accept_i;

endmodule

### sv/pvlu_queue.sv
// two-entry command queue between front and back end
module pvlu_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  pvlu_pkg::cmd_t       push_data_i,
  input  logic                 pop_i,
  output pvlu_pkg::cmd_t       head_o,
  output pvlu_pkg::q_status_t  status_o
);

  localparam int PTR_W = $clog2(pvlu_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(pvlu_pkg::QUEUE_DEPTH + 1);

  pvlu_pkg::cmd_t   entry_q [pvlu_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == CNT_W'(pvlu_pkg::QUEUE_DEPTH));
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + CNT_W'(1);
        2'b01:   count_q <= count_q - CNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

### sv/pvlu_back.sv
// back end: plane memories, latches, clearing pass and access sequencer
module pvlu_back #(
  parameter int PLANE_ADDR_BITS = 14
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pvlu_pkg::cmd_t                head_i,
  input  pvlu_pkg::q_status_t           q_status_i,
  output logic                          pop_o,
  output logic                          clearing_o,
  output logic                          rdata_valid_o,
  output logic [pvlu_pkg::DATA_W-1:0]   rdata_o
);

  localparam int AW    = PLANE_ADDR_BITS;
  localparam int DEPTH = 1 << PLANE_ADDR_BITS;
  localparam int NP    = pvlu_pkg::NUM_PLANES;
  localparam int DW    = pvlu_pkg::DATA_W;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_e;

  state_e                  state_q;
  pvlu_pkg::cmd_t          cmd_q;
  logic [AW-1:0]           clr_addr_q;
  logic [NP-1:0][DW-1:0]   latch_q;
  logic [NP-1:0][DW-1:0]   rd;
  logic [NP-1:0][DW-1:0]   wd;
  logic [NP-1:0]           we;
  logic [AW-1:0]           raddr, waddr;
  logic [DW-1:0]           result;
  logic [DW-1:0]           mask;
  logic                    latch_ld;

  assign pop_o      = (state_q == S_IDLE) && !q_status_i.empty;
  assign clearing_o = (state_q == S_CLEAR);
  assign raddr      = AW'(head_i.addr);
  assign waddr      = (state_q == S_CLEAR) ? clr_addr_q : AW'(cmd_q.addr);

  for (genvar p = 0; p < NP; p++) begin : g_plane
    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_q;
    always_ff @(posedge clk_i) begin
      if (we[p]) begin
        mem[waddr] <= wd[p];
      end
      if (pop_o) begin
        rd_q <= mem[raddr];
      end
    end
    assign rd[p] = rd_q;
  end

  // compare mask over the three plane bytes
  always_comb begin
    mask = '1;
    for (int p = 0; p < NP; p++) begin
      mask = mask & (cmd_q.compare_color[p] ? rd[p] : ~rd[p]);
    end
  end

  always_comb begin
    we       = '0;
    wd       = rd;
    result   = '0;
    latch_ld = 1'b0;
    if (state_q == S_CLEAR) begin
      we = '1;
      wd = '0;
    end else if (state_q == S_EXEC) begin
      case (cmd_q.kind)
        pvlu_pkg::KIND_ALU_RD: begin
          latch_ld = 1'b1;
          result   = mask;
        end
        pvlu_pkg::KIND_ALU_WR: begin
          case (cmd_q.write_mode)
            pvlu_pkg::WMODE_LOGIC: begin
              we = '1;
              for (int p = 0; p < NP; p++) begin
                wd[p] = pvlu_pkg::apply_op(rd[p], cmd_q.plane_ops, 2'(p), cmd_q.wdata);
              end
            end
            pvlu_pkg::WMODE_RESTORE: begin
              we = '1;
              wd = latch_q;
            end
            pvlu_pkg::WMODE_L1_TO_P0: begin
              we[0] = 1'b1;
              wd[0] = latch_q[1];
            end
            default: begin
              we[1] = 1'b1;
              wd[1] = latch_q[0];
            end
          endcase
        end
        pvlu_pkg::KIND_DIRECT_RD: begin
          for (int p = 0; p < NP; p++) begin
            if (cmd_q.plane == 2'(p)) begin
              result = rd[p];
            end
          end
        end
        pvlu_pkg::KIND_DIRECT_WR: begin
          for (int p = 0; p < NP; p++) begin
            if (cmd_q.plane == 2'(p)) begin
              we[p] = 1'b1;
              wd[p] = cmd_q.wdata;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLEAR;
      cmd_q         <= '0;
      clr_addr_q    <= '0;
      latch_q       <= '0;
      rdata_valid_o <= 1'b0;
      rdata_o       <= '0;
    end else begin
      rdata_valid_o <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          clr_addr_q <= clr_addr_q + AW'(1);
          if (&clr_addr_q) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (pop_o) begin
            cmd_q   <= head_i;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          rdata_valid_o <= 1'b1;
          rdata_o       <= result;
          if (latch_ld) begin
            latch_q <= rd;
          end
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

### sv/planar_vram_logic_unit.sv
// top level of the three-plane graphics memory with its logic unit
//
//   channel  | ports                               | handshake
//   ---------+-------------------------------------+--------------------------------
//   command  | op_i, addr_i, wdata_i               | beat when start high, busy low
//   result   | rdata_o                             | beat on rdata_valid_o, one cycle
//   config   | cfg_idx_i, cfg_wdata_i              | beat on cfg_we_i, no wait
//
// one access at a time: accept into the command queue, pop and plane memory
// read, execute with write-back, result beat; the registered read port of the
// plane memories and the read-modify-write sequencer set these steps, and busy
// holds a new access off until the result beat of the last one has shown.
// after reset a clearing pass zeroes all three planes, one address per cycle,
// all 2**PLANE_ADDR_BITS addresses, busy high; config writes are taken meanwhile.
// the receiver cannot stall, so busy only tracks the clearing pass and the
// access in flight.
module planar_vram_logic_unit #(
  parameter int PLANE_ADDR_BITS = 14
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic                             op_i,
  input  logic [pvlu_pkg::ADDR_W-1:0]      addr_i,
  input  logic [pvlu_pkg::DATA_W-1:0]      wdata_i,
  output logic                             rdata_valid_o,
  output logic [pvlu_pkg::DATA_W-1:0]      rdata_o,
  input  logic                             cfg_we_i,
  input  logic [pvlu_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [pvlu_pkg::DATA_W-1:0]      cfg_wdata_i
);

  logic                accept;
  logic                push;
  logic                pop;
  logic                clearing;
  logic                outstanding_q;
  pvlu_pkg::cmd_t      push_cmd;
  pvlu_pkg::cmd_t      head_cmd;
  pvlu_pkg::q_status_t q_status;

  // busy while planes are being cleared or an access has not yet returned
  assign busy   = clearing || outstanding_q;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outstanding_q <= 1'b0;
    end else if (accept) begin
      outstanding_q <= 1'b1;
    end else if (rdata_valid_o) begin
      outstanding_q <= 1'b0;
    end
  end

  // front end: config registers and access classification
  pvlu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .op_i        (op_i),
    .addr_i      (addr_i),
    .wdata_i     (wdata_i),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  // decouples classification from execution
  pvlu_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .pop_i       (pop),
    .head_o      (head_cmd),
    .status_o    (q_status)
  );

  // back end: planes, latches and the read-modify-write sequencer
  pvlu_back #(
    .PLANE_ADDR_BITS (PLANE_ADDR_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head_cmd),
    .q_status_i    (q_status),
    .pop_o         (pop),
    .clearing_o    (clearing),
    .rdata_valid_o (rdata_valid_o),
    .rdata_o       (rdata_o)
  );

  // a result only for an access in flight
  a_result_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rdata_valid_o |-> outstanding_q)
    else $error("result beat without an access in flight");

  // no two result beats back to back
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rdata_valid_o |=> !rdata_valid_o)
    else $error("repeated result beat");

  // the queue is drained before a new access enters
  a_queue_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> q_status.empty)
    else $error("access accepted with queue occupied");

  // no result in the cycle right after an accept
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !rdata_valid_o)
    else $error("result beat too early");

endmodule
